// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers shared by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds, consequent holds in the same cycle
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// antecedent holds, consequent holds in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// File: hw/rtl/sgt_pkg.sv
// ----------------------------------------------------------------------------
// sgt_pkg
// shared constants for the sequence gap tracker
// ----------------------------------------------------------------------------
`default_nettype none

package sgt_pkg;

	localparam int SEQ_W = 32;
	localparam int ACT_W = 3;

	typedef logic [SEQ_W-1:0] seq_t;
	typedef logic [ACT_W-1:0] act_t;

	localparam act_t ACT_FIRST       = 3'd0;
	localparam act_t ACT_IN_ORDER    = 3'd1;
	localparam act_t ACT_GAP_CLOSED  = 3'd2;
	localparam act_t ACT_FIRST_CHUNK = 3'd3;
	localparam act_t ACT_NEW_CHUNK   = 3'd4;
	localparam act_t ACT_APPENDED    = 3'd5;
	localparam act_t ACT_STALE       = 3'd6;
	localparam act_t ACT_RING_FULL   = 3'd7;

endpackage

`default_nettype wire

// File: hw/rtl/sgt_chunk_ram.sv
// ----------------------------------------------------------------------------
// sgt_chunk_ram
// chunk bound store: one write port, two registered read ports
// ----------------------------------------------------------------------------
`default_nettype none

module sgt_chunk_ram import sgt_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire seq_t          wdata,
	input  wire logic [AW-1:0] raddr0,
	input  wire logic [AW-1:0] raddr1,
	output seq_t               rdata0,
	output seq_t               rdata1
);

	seq_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read data is registered and follows the address in the next cycle
	always_ff @(posedge clk) begin
		rdata0 <= mem_q[raddr0];
		rdata1 <= mem_q[raddr1];
	end

endmodule

`default_nettype wire

// File: hw/rtl/sequence_gap_tracker_core.sv
// ----------------------------------------------------------------------------
// sequence_gap_tracker_core
// tracks the contiguous run of sequence numbers and a ring of out-of-order
// chunks, reporting the action taken and the range to request again
// ----------------------------------------------------------------------------
//   channel   dir  payload
//   s_axis    in   seq_number
//   m_axis    out  action, run_end, gap_pending, request_begin, request_end,
//                  chunks_held
//
// each request takes two steps: one to read the front, next-front and back
// chunk entries from the chunk rams, one to decide and write back
// a finished result sits in the output register; the next request is taken
// while it waits, but its decision stalls until the register is free
// asynchronous reset clears the run and the ring pointers; the chunk rams are
// not cleared, only entries inside the ring window are ever read
// ----------------------------------------------------------------------------
`default_nettype none

module sequence_gap_tracker_core import sgt_pkg::*; #(
	parameter int MAX_CHUNKS = 16,
	localparam int IDX_W = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1,
	localparam int CNT_W = $clog2(MAX_CHUNKS + 1),
	localparam int OUT_BITS = ACT_W + 3 * SEQ_W + 1 + CNT_W,
	localparam int OUT_W = ((OUT_BITS + 7) / 8) * 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_axis_tvalid,
	output logic                  s_axis_tready,
	input  wire logic [SEQ_W-1:0] s_axis_tdata,  // seq_number
	output logic                  m_axis_tvalid,
	input  wire logic             m_axis_tready,
	// action, run_end, gap_pending, request_begin, request_end, chunks_held, zero fill
	output logic [OUT_W-1:0]      m_axis_tdata
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_CALC = 1'b1;

	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_CHUNKS - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_CHUNKS);

	logic             state_q;
	logic             started_q;
	seq_t             run_last_q;
	logic [IDX_W-1:0] head_q;
	logic [IDX_W-1:0] tail_q;
	logic [CNT_W-1:0] count_q;
	seq_t             seq_s1;
	logic             out_valid_q;
	logic [OUT_W-1:0] out_data_q;

	logic [IDX_W-1:0] head_inc;
	logic [IDX_W-1:0] tail_inc;
	logic [IDX_W-1:0] back_idx;

	seq_t front_first;
	seq_t next_first;
	seq_t front_last;
	seq_t back_last;

	logic             accept;
	logic             calc_go;
	logic [SEQ_W:0]   s_ext;
	logic [SEQ_W:0]   run_next;
	logic [SEQ_W:0]   chunk_next;
	logic             merge;
	logic             push;
	logic             append;
	act_t             act_n;
	seq_t             run_last_n;
	logic [IDX_W-1:0] head_n;
	logic [CNT_W-1:0] count_n;
	seq_t             req_begin_n;
	seq_t             req_end_n;
	logic             gap_n;
	logic             last_we;
	logic [IDX_W-1:0] last_waddr;

	assign head_inc = (head_q == IDX_LAST) ? '0 : head_q + 1'b1;
	assign tail_inc = (tail_q == IDX_LAST) ? '0 : tail_q + 1'b1;
	assign back_idx = (tail_q == '0) ? IDX_LAST : tail_q - 1'b1;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign calc_go       = (state_q == ST_CALC) && (!out_valid_q || m_axis_tready);

	sgt_chunk_ram #(.DEPTH(MAX_CHUNKS), .AW(IDX_W)) u_first_ram (
		.clk    (clk),
		.we     (calc_go && push),
		.waddr  (tail_q),
		.wdata  (seq_s1),
		.raddr0 (head_q),
		.raddr1 (head_inc),
		.rdata0 (front_first),
		.rdata1 (next_first)
	);

	sgt_chunk_ram #(.DEPTH(MAX_CHUNKS), .AW(IDX_W)) u_last_ram (
		.clk    (clk),
		.we     (last_we),
		.waddr  (last_waddr),
		.wdata  (seq_s1),
		.raddr0 (head_q),
		.raddr1 (back_idx),
		.rdata0 (front_last),
		.rdata1 (back_last)
	);

	assign last_we    = calc_go && (push || append);
	assign last_waddr = push ? tail_q : back_idx;

	// compares run one bit wider so a run or chunk ending at the top stays closed
	assign s_ext      = {1'b0, seq_s1};
	assign run_next   = {1'b0, run_last_q} + 1'b1;
	assign chunk_next = {1'b0, back_last} + 1'b1;
	assign merge      = (count_q != '0) && ({1'b0, front_first} == s_ext + 1'b1);

	always_comb begin
		act_n      = ACT_STALE;
		run_last_n = run_last_q;
		head_n     = head_q;
		count_n    = count_q;
		push       = 1'b0;
		append     = 1'b0;
		if (!started_q) begin
			act_n      = ACT_FIRST;
			run_last_n = seq_s1;
		end else if (s_ext < run_next) begin
			act_n = ACT_STALE;
		end else if (s_ext == run_next) begin
			act_n      = ACT_IN_ORDER;
			run_last_n = seq_s1;
			if (merge) begin
				act_n      = ACT_GAP_CLOSED;
				run_last_n = front_last;
				head_n     = head_inc;
				count_n    = count_q - 1'b1;
			end
		end else if (count_q == '0) begin
			act_n   = ACT_FIRST_CHUNK;
			push    = 1'b1;
			count_n = count_q + 1'b1;
		end else if (s_ext < chunk_next) begin
			act_n = ACT_STALE;
		end else if (s_ext == chunk_next) begin
			act_n  = ACT_APPENDED;
			append = 1'b1;
		end else if (count_q >= CNT_FULL) begin
			act_n = ACT_RING_FULL;
		end else begin
			act_n   = ACT_NEW_CHUNK;
			push    = 1'b1;
			count_n = count_q + 1'b1;
		end
	end

	always_comb begin
		gap_n       = (count_n != '0);
		req_begin_n = gap_n ? run_last_n + 1'b1 : '0;
		req_end_n   = '0;
		if (gap_n) begin
			case (act_n)
				ACT_FIRST_CHUNK: req_end_n = seq_s1;
				ACT_GAP_CLOSED:  req_end_n = next_first;
				default:         req_end_n = front_first;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			started_q   <= 1'b0;
			run_last_q  <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					if (calc_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (calc_go) begin
				started_q  <= 1'b1;
				run_last_q <= run_last_n;
				head_q     <= head_n;
				count_q    <= count_n;
				if (push) begin
					tail_q <= tail_inc;
				end
			end
			if (calc_go) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			seq_s1 <= s_axis_tdata;
		end
		if (calc_go) begin
			out_data_q <= OUT_W'({count_n, req_end_n, req_begin_n, gap_n, run_last_n, act_n});
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

`include "assert_macros.svh"

	`ASSERT_IMPL(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_FULL)
	`ASSERT_IMPL(a_empty_ring, clk, arst_n, count_q == '0, head_q == tail_q)
	`ASSERT_IMPL(a_full_drop, clk, arst_n, calc_go && act_n == ACT_RING_FULL, count_q == CNT_FULL)
	`ASSERT_NEXT(a_calc_follows, clk, arst_n, accept, state_q == ST_CALC && !s_axis_tready)

endmodule

`default_nettype wire

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for sequence_gap_tracker_core: a clocked driver feeds
// sequence numbers from a queue of lossy, reordered message streams, a
// clocked monitor compares every result with an independent tracker model
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import sgt_pkg::*;

	localparam int RING = 16;
	localparam int CNT_BITS = $clog2(RING + 1);
	localparam int OUT_W = ((ACT_W + 3 * SEQ_W + 1 + CNT_BITS + 7) / 8) * 8;
	localparam int CYCLE_LIMIT = 400000;
	localparam seq_t TOP = 32'hFFFF_FFFF;

	typedef struct packed {
		act_t                action;
		seq_t                run_end;
		logic                gap_pending;
		seq_t                request_begin;
		seq_t                request_end;
		logic [CNT_BITS-1:0] chunks_held;
	} gap_report_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [SEQ_W-1:0] s_axis_tdata = '0;  // seq_number
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	// action, run_end, gap_pending, request_begin, request_end, chunks_held, zero fill
	logic [OUT_W-1:0] m_axis_tdata;

	sequence_gap_tracker_core #(
		.MAX_CHUNKS(RING)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#5 clk = 1'b0;
		#5 clk = 1'b1;
	end

	// two copies of the tracker: 0 follows the stimulus as it is built, 1 the
	// requests the block actually takes
	logic run_started_tab [2];
	seq_t run_last_tab    [2];
	seq_t chunk_first_tab [2][RING];
	seq_t chunk_last_tab  [2][RING];
	int   ring_head_tab   [2];
	int   ring_tail_tab   [2];
	int   ring_count_tab  [2];

	seq_t        seq_pending[$];
	gap_report_t report_expected[$];
	int          mismatches = 0;
	int          cycle_count = 0;

	function automatic void clear_tracker(input int ctx);
		run_started_tab[ctx] = 1'b0;
		run_last_tab[ctx] = '0;
		ring_head_tab[ctx] = 0;
		ring_tail_tab[ctx] = 0;
		ring_count_tab[ctx] = 0;
	endfunction

	function automatic void open_chunk(input int ctx, input seq_t seq);
		chunk_first_tab[ctx][ring_tail_tab[ctx]] = seq;
		chunk_last_tab[ctx][ring_tail_tab[ctx]] = seq;
		ring_tail_tab[ctx] = (ring_tail_tab[ctx] + 1) % RING;
		ring_count_tab[ctx]++;
	endfunction

	function automatic void track_number(input int ctx, input seq_t seq,
		output gap_report_t rep);
		logic [SEQ_W:0] run_next;
		logic [SEQ_W:0] back_next;
		logic [SEQ_W:0] wide;
		int             h;
		int             b;
		act_t           act;
		wide = {1'b0, seq};
		if (!run_started_tab[ctx]) begin
			run_started_tab[ctx] = 1'b1;
			run_last_tab[ctx] = seq;
			act = ACT_FIRST;
		end else begin
			// compares in 33 bits so a run or chunk at the top has no next number
			run_next = {1'b0, run_last_tab[ctx]} + 1'b1;
			if (wide < run_next) begin
				act = ACT_STALE;
			end else if (wide == run_next) begin
				run_last_tab[ctx] = seq;
				act = ACT_IN_ORDER;
				h = ring_head_tab[ctx];
				if (ring_count_tab[ctx] > 0 && {1'b0, chunk_first_tab[ctx][h]} == wide + 1'b1) begin
					run_last_tab[ctx] = chunk_last_tab[ctx][h];
					ring_head_tab[ctx] = (h + 1) % RING;
					ring_count_tab[ctx]--;
					act = ACT_GAP_CLOSED;
				end
			end else if (ring_count_tab[ctx] == 0) begin
				open_chunk(ctx, seq);
				act = ACT_FIRST_CHUNK;
			end else begin
				b = (ring_tail_tab[ctx] + RING - 1) % RING;
				back_next = {1'b0, chunk_last_tab[ctx][b]} + 1'b1;
				if (wide < back_next) begin
					act = ACT_STALE;
				end else if (wide == back_next) begin
					chunk_last_tab[ctx][b] = seq;
					act = ACT_APPENDED;
				end else if (ring_count_tab[ctx] >= RING) begin
					act = ACT_RING_FULL;
				end else begin
					open_chunk(ctx, seq);
					act = ACT_NEW_CHUNK;
				end
			end
		end
		rep.action = act;
		rep.run_end = run_started_tab[ctx] ? run_last_tab[ctx] : '0;
		rep.gap_pending = (ring_count_tab[ctx] > 0);
		rep.request_begin = rep.gap_pending ? run_last_tab[ctx] + 1'b1 : '0;
		rep.request_end = rep.gap_pending ? chunk_first_tab[ctx][ring_head_tab[ctx]] : '0;
		rep.chunks_held = ring_count_tab[ctx][CNT_BITS-1:0];
	endfunction

	// ---------------------------------------------------------------- stimulus

	seq_t next_new;
	seq_t first_seq;

	function automatic void offer(input seq_t seq);
		gap_report_t rep;
		track_number(0, seq, rep);
		seq_pending.insert(seq_pending.size(), seq);
	endfunction

	// resend the missing numbers the way a receiver would request them
	function automatic void fill_gaps(input int budget);
		int n;
		n = 0;
		while (n < budget && ({1'b0, run_last_tab[0]} + 1'b1) < {1'b0, next_new}) begin
			offer(run_last_tab[0] + 1'b1);
			n++;
		end
	endfunction

	function automatic void random_stream();
		seq_t win[$];
		seq_t tmp;
		int   w;
		int   k;
		int   mode;
		while (next_new < TOP - 32'd120) begin
			mode = $urandom_range(0, 9);
			if (mode == 0) begin
				k = $urandom_range(1, 3);
				for (int i = 0; i < k; i++) begin
					case ($urandom_range(0, 2))
						0: offer($urandom_range(first_seq - 1'b1));
						1: offer(run_last_tab[0] - $urandom_range(0, 6));
						default: offer(next_new - $urandom_range(1, 4));
					endcase
				end
			end else if (mode == 1) begin
				// scattered singles, enough to run the ring full
				k = $urandom_range(2, 20);
				for (int i = 0; i < k; i++) begin
					next_new = next_new + $urandom_range(1, 2);
					offer(next_new);
				end
				next_new = next_new + 1'b1;
			end else begin
				w = $urandom_range(1, 16);
				win.delete();
				for (int i = 0; i < w; i++) begin
					if ($urandom_range(0, 5) != 0)
						win.insert(win.size(), next_new + i);
					if ($urandom_range(0, 9) == 0)
						win.insert(win.size(), next_new + i);
				end
				for (int i = 0; i + 1 < win.size(); i++) begin
					if ($urandom_range(0, 7) == 0) begin
						tmp = win[i];
						win[i] = win[i+1];
						win[i+1] = tmp;
					end
				end
				foreach (win[i])
					offer(win[i]);
				next_new = next_new + w;
			end
			if ($urandom_range(0, 3) != 0 || ring_count_tab[0] >= RING - 4)
				fill_gaps($urandom_range(1, 48));
		end
	endfunction

	function automatic void build_stimulus();
		first_seq = TOP - 32'd1100 - $urandom_range(0, 63);
		offer(first_seq);
		offer(first_seq + 1);
		offer(first_seq + 3);
		offer(first_seq + 4);
		offer(first_seq + 6);
		// inside the gap between two chunks: dropped even though it fits
		offer(first_seq + 5);
		offer(first_seq + 2);
		offer(first_seq + 3);
		for (int i = 0; i < RING; i++)
			offer(first_seq + 8 + 2 * i);
		offer(first_seq + 8 + 2 * RING + 1);
		offer(first_seq + 8 + 2 * RING - 1);
		next_new = first_seq + 8 + 2 * RING + 2;

		random_stream();

		// chunk at the top, then the run is carried up to it
		fill_gaps(1 << 20);
		offer(TOP - 1);
		offer(TOP);
		offer(TOP);
		offer(TOP - 2);
		next_new = TOP - 1;
		fill_gaps(1 << 20);
		// run at the top: nothing can follow it any more
		offer(TOP);
		offer('0);
		offer(32'h8000_0000);
	endfunction

	// ---------------------------------------------------------------- driver

	int   send_idle;
	logic send_calm;

	always @(posedge clk or negedge arst_n) begin
		gap_report_t rep;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			send_idle <= 0;
			send_calm <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				track_number(1, s_axis_tdata, rep);
				report_expected.insert(report_expected.size(), rep);
			end
			if (s_axis_tvalid && !s_axis_tready) begin
				// request still waiting, hold it
			end else if (send_idle > 0) begin
				s_axis_tvalid <= 1'b0;
				send_idle <= send_idle - 1;
			end else if (seq_pending.size() > 0) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= seq_pending[0];
				seq_pending.delete(0);
				send_idle <= send_calm ? 0 : $urandom_range(0, 9);
				if ($urandom_range(0, 59) == 0)
					send_calm <= !send_calm;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------- monitor

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	int   recv_stall;
	logic recv_calm;

	always @(posedge clk or negedge arst_n) begin
		gap_report_t got;
		gap_report_t exp;
		int          n;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			recv_stall <= 0;
			recv_calm <= 1'b0;
		end else if (m_axis_tvalid && m_axis_tready) begin
			got.action = m_axis_tdata[ACT_W-1:0];
			got.run_end = m_axis_tdata[ACT_W +: SEQ_W];
			got.gap_pending = m_axis_tdata[ACT_W + SEQ_W];
			got.request_begin = m_axis_tdata[ACT_W + SEQ_W + 1 +: SEQ_W];
			got.request_end = m_axis_tdata[ACT_W + 2 * SEQ_W + 1 +: SEQ_W];
			got.chunks_held = m_axis_tdata[ACT_W + 3 * SEQ_W + 1 +: CNT_BITS];
			if (report_expected.size() == 0) begin
				report_mismatch($sformatf("result with nothing expected, tdata %h",
					m_axis_tdata));
			end else begin
				exp = report_expected[0];
				report_expected.delete(0);
				if (got.action !== exp.action)
					report_mismatch($sformatf("action exp %0d got %0d",
						exp.action, got.action));
				if (got.run_end !== exp.run_end)
					report_mismatch($sformatf("run_end exp %h got %h",
						exp.run_end, got.run_end));
				if (got.gap_pending !== exp.gap_pending)
					report_mismatch($sformatf("gap_pending exp %b got %b",
						exp.gap_pending, got.gap_pending));
				if (got.request_begin !== exp.request_begin)
					report_mismatch($sformatf("request_begin exp %h got %h",
						exp.request_begin, got.request_begin));
				if (got.request_end !== exp.request_end)
					report_mismatch($sformatf("request_end exp %h got %h",
						exp.request_end, got.request_end));
				if (got.chunks_held !== exp.chunks_held)
					report_mismatch($sformatf("chunks_held exp %0d got %0d",
						exp.chunks_held, got.chunks_held));
			end
			n = recv_calm ? 0 : $urandom_range(0, 9);
			if ($urandom_range(0, 59) == 0)
				recv_calm <= !recv_calm;
			if (n == 0) begin
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b0;
				recv_stall <= n - 1;
			end
		end else if (recv_stall > 0) begin
			m_axis_tready <= 1'b0;
			recv_stall <= recv_stall - 1;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// ---------------------------------------------------------------- control

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("sequence_gap_tracker_core verification failed");
			$finish;
		end
	end

	initial begin
		clear_tracker(0);
		clear_tracker(1);
		build_stimulus();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		while (seq_pending.size() != 0 || s_axis_tvalid)
			@(posedge clk);
		while (report_expected.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("sequence_gap_tracker_core verification clean");
		else
			$display("sequence_gap_tracker_core verification failed");
		$finish;
	end

endmodule

`default_nettype wire
